/* hdl/kbq_pkg.sv */
package kbq_pkg;

    // Queue and key table sizes.
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int KEY_SLOTS   = 256;
    localparam int SLOT_W      = $clog2(KEY_SLOTS);
    localparam int CNT_W       = 16;

    // Field widths.
    localparam int RAW_W  = 8;
    localparam int SCAN_W = 8;
    localparam int KIND_W = 2;
    localparam int MASK_W = 9;

    // Operation codes.
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Key state codes.
    localparam logic [1:0] KS_NONE    = 2'd0;
    localparam logic [1:0] KS_RELEASE = 2'd3;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_DOWN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // Modifier scan codes.
    localparam int MOD_LSHIFT = 225;
    localparam int MOD_RSHIFT = 229;
    localparam int MOD_LCTRL  = 224;
    localparam int MOD_LALT   = 226;

    // Controller states.
    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic feed;
        logic pop;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_pop;
        logic out_free;
    } t_status;

    // One stored queue entry.
    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic              release_n;
        logic [SCAN_W-1:0] scan;
        logic [MASK_W-1:0] mask;
    } t_entry;

    // One result of a pop.
    typedef struct packed {
        logic              event_valid;
        logic [KIND_W-1:0] event_kind;
        logic [RAW_W-1:0]  event_raw;
        logic [SCAN_W-1:0] event_scan;
        logic [MASK_W-1:0] modifier_mask;
        logic [CNT_W-1:0]  overflow_total;
    } t_result;

    // Raw keyboard code to HID scan code; zero means unmapped.
    function automatic logic [SCAN_W-1:0] to_hid(input logic [RAW_W-1:0] k);
        logic [SCAN_W-1:0] sc;
        case (k) inside
            [8'h61:8'h7A]: sc = k - 8'h61 + 8'd4;
            [8'h41:8'h5A]: sc = k - 8'h41 + 8'd4;
            [8'h31:8'h39]: sc = k - 8'h31 + 8'd30;
            8'h30:         sc = 8'd39;
            [8'h81:8'h89]: sc = k - 8'h81 + 8'd58;
            8'h90:         sc = 8'd67;
            8'h08:         sc = 8'd42;
            8'h09:         sc = 8'd43;
            8'h0A, 8'h0D:  sc = 8'd40;
            8'h20:         sc = 8'd44;
            8'hB1:         sc = 8'd41;
            8'hB4:         sc = 8'd80;
            8'hB5:         sc = 8'd82;
            8'hB6:         sc = 8'd81;
            8'hB7:         sc = 8'd79;
            8'hA1:         sc = 8'd226;
            8'hA2:         sc = 8'd225;
            8'hA3:         sc = 8'd229;
            8'hA5:         sc = 8'd224;
            8'hD1:         sc = 8'd73;
            8'hD2:         sc = 8'd74;
            8'hD4:         sc = 8'd76;
            8'hD5:         sc = 8'd77;
            8'hD6:         sc = 8'd75;
            8'hD7:         sc = 8'd78;
            8'hC1:         sc = 8'd57;
            8'h2D:         sc = 8'd45;
            8'h3D:         sc = 8'd46;
            8'h5B:         sc = 8'd47;
            8'h5D:         sc = 8'd48;
            8'h5C:         sc = 8'd49;
            8'h3B:         sc = 8'd51;
            8'h27:         sc = 8'd52;
            8'h60:         sc = 8'd53;
            8'h2C:         sc = 8'd54;
            8'h2E:         sc = 8'd55;
            8'h2F:         sc = 8'd56;
            default:       sc = '0;
        endcase
        return sc;
    endfunction

endpackage

/* hdl/kbq_if.sv */
// Request channel: one feed or pop per transaction.
interface kbq_in_if
    import kbq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [RAW_W-1:0] raw_key;
    logic [1:0]       key_state;

    modport source (output valid, opcode, raw_key, key_state, input ready);
    modport sink   (input valid, opcode, raw_key, key_state, output ready);
endinterface

// Result channel: one event or empty answer per transaction.
interface kbq_out_if
    import kbq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [KIND_W-1:0] event_kind;
    logic [RAW_W-1:0]  event_raw;
    logic [SCAN_W-1:0] event_scan;
    logic [MASK_W-1:0] modifier_mask;
    logic [CNT_W-1:0]  overflow_total;

    modport source (output valid, event_valid, event_kind, event_raw, event_scan,
                    modifier_mask, overflow_total, input ready);
    modport sink   (input valid, event_valid, event_kind, event_raw, event_scan,
                    modifier_mask, overflow_total, output ready);
endinterface

/* hdl/kbq_ctrl.sv */
module kbq_ctrl
    import kbq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.is_pop) begin
                    o_cmd.feed = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.out_free) begin
                    // A pop waits here until the result register can take it.
                    o_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/kbq_datapath.sv */
module kbq_datapath
    import kbq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_opcode,
    input  logic [RAW_W-1:0] i_raw_key,
    input  logic [1:0]       i_key_state,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    kbq_out_if.source        o_out
);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    // Latched request.
    logic             r_opcode;
    logic [RAW_W-1:0] r_raw;
    logic [1:0]       r_key_state;

    // Queue state.
    logic [KEY_SLOTS-1:0] r_held;
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_ovf_count;
    logic                 r_reset_owed;
    t_entry               r_mem [QUEUE_DEPTH];
    t_entry               r_rd_data;

    // Result register.
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;

    // Feed evaluation.
    logic [SCAN_W-1:0]    scan;
    logic [SLOT_W-1:0]    slot;
    logic                 is_release;
    logic                 live;
    logic                 full;
    logic                 empty;
    logic [PTR_W-1:0]     wr_next;
    logic [PTR_W-1:0]     rd_next;
    logic [KEY_SLOTS-1:0] n_held;
    logic [MASK_W-1:0]    mask;
    t_entry               new_entry;

    // Translate, check the held bit and form the entry with the updated mask.
    always_comb begin
        scan       = to_hid(r_raw);
        slot       = SLOT_W'(scan);
        is_release = (r_key_state == KS_RELEASE);
        live       = (scan != '0) && (r_key_state != KS_NONE) &&
                     (is_release == r_held[slot]);
        wr_next    = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        rd_next    = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        full       = (wr_next == r_rd_ptr);
        empty      = (r_rd_ptr == r_wr_ptr);
        n_held       = r_held;
        n_held[slot] = !is_release;
        mask = {n_held[MOD_LALT], 1'b0, n_held[MOD_LCTRL], 4'b0000,
                n_held[MOD_RSHIFT], n_held[MOD_LSHIFT]};
        new_entry.raw       = r_raw;
        new_entry.release_n = is_release;
        new_entry.scan      = scan;
        new_entry.mask      = mask;
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode    <= i_opcode;
            r_raw       <= i_raw_key;
            r_key_state <= i_key_state;
        end
    end

    // Event store: one write port, read data registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.feed && live && !full) begin
            r_mem[r_wr_ptr] <= new_entry;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // Pointers, held bits, overflow counter and owed reset event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_ovf_count  <= '0;
            r_reset_owed <= 1'b0;
        end else if (i_cmd.feed && live) begin
            if (full) begin
                r_held       <= '0;
                r_wr_ptr     <= '0;
                r_rd_ptr     <= '0;
                r_reset_owed <= 1'b1;
                if (r_ovf_count != CNT_MAX) begin
                    r_ovf_count <= r_ovf_count + 1'b1;
                end
            end else begin
                r_held   <= n_held;
                r_wr_ptr <= wr_next;
            end
        end else if (i_cmd.pop) begin
            if (r_reset_owed) begin
                r_reset_owed <= 1'b0;
            end else if (!empty) begin
                r_rd_ptr <= rd_next;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Next result: reset event, empty answer or oldest entry.
    always_comb begin
        n_result                = '0;
        n_result.overflow_total = r_ovf_count;
        if (r_reset_owed) begin
            n_result.event_valid = 1'b1;
            n_result.event_kind  = KIND_RESET;
        end else if (!empty) begin
            n_result.event_valid   = 1'b1;
            n_result.event_kind    = r_rd_data.release_n ? KIND_UP : KIND_DOWN;
            n_result.event_raw     = r_rd_data.raw;
            n_result.event_scan    = r_rd_data.scan;
            n_result.modifier_mask = r_rd_data.mask;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_result <= n_result;
        end
    end

    // Status and output channel.
    assign o_status.is_pop   = (r_opcode == OP_POP);
    assign o_status.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.event_valid    = r_result.event_valid;
    assign o_out.event_kind     = r_result.event_kind;
    assign o_out.event_raw      = r_result.event_raw;
    assign o_out.event_scan     = r_result.event_scan;
    assign o_out.modifier_mask  = r_result.modifier_mask;
    assign o_out.overflow_total = r_result.overflow_total;

endmodule

/* hdl/keyboard_event_queue_core.sv */
// Keyboard event queue with HID scan code translation.
//
// Requests arrive on i_in (valid/ready). Opcode feed offers a raw key code
// and a key state; a feed causes no result. Opcode pop asks for the next
// event; each pop gives exactly one transaction on o_out, either an event
// (event_valid high) or an empty answer, with the current overflow count.
// The queue holds 63 events. A feed that finds it full clears the queue and
// all held keys, bumps the saturating overflow count and makes the next pop
// return an input reset event.
// Each request is accepted in the idle state and then executed in the execute
// state against the held-key register and the event store, whose read port is
// registered. The block does not accept a new request until the last one has
// executed. A pop result is on o_out in the cycle after execution.
// The result register decouples the two sides: a feed is accepted and runs
// while a result waits; a pop waits in execution until the result register
// is free. Reset clears the pointers, held keys, counter and owed reset
// event; the store contents need no clearing.
module keyboard_event_queue_core
    import kbq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbq_in_if.sink    i_in,
    kbq_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    // Sequencing of accept and execute.
    kbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Translation, held keys, event store and result register.
    kbq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opcode    (i_in.opcode),
        .i_raw_key   (i_in.raw_key),
        .i_key_state (i_in.key_state),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule
